### rtl/fpr_pkg.sv
package fpr_pkg;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LENGTH = 3'd1,
        PH_DATA   = 3'd2,
        PH_CHECK  = 3'd3,
        PH_END    = 3'd4
    } t_phase;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_DATA   = 2'd0;
    localparam t_kind KIND_GOOD   = 2'd1;
    localparam t_kind KIND_BADSUM = 2'd2;
    localparam t_kind KIND_NOEND  = 2'd3;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] length_seen;
        logic [7:0] byte_count;
        logic [7:0] running_xor;
        logic [7:0] checksum_seen;
    } t_state;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_length;
    } t_result;

endpackage

### rtl/fpr_step.sv
module fpr_step (
    input  fpr_pkg::t_state  i_state,
    input  logic [7:0]       i_rx_byte,
    output fpr_pkg::t_state  o_state,
    output fpr_pkg::t_result o_result
);

    logic [7:0] count_inc;

    assign count_inc = i_state.byte_count + 8'd1;

    always_comb begin
        o_state                = i_state;
        o_result.valid         = 1'b0;
        o_result.kind          = fpr_pkg::KIND_DATA;
        o_result.payload_byte  = 8'd0;
        o_result.payload_index = 8'd0;
        o_result.frame_length  = i_state.length_seen;

        unique case (i_state.phase)
            fpr_pkg::PH_HUNT: begin
                if (i_rx_byte == fpr_pkg::START_BYTE) begin
                    o_state.running_xor = 8'd0;
                    o_state.phase       = fpr_pkg::PH_LENGTH;
                end
            end
            fpr_pkg::PH_LENGTH: begin
                o_state.length_seen = i_rx_byte;
                o_state.running_xor = i_state.running_xor ^ i_rx_byte;
                o_state.byte_count  = 8'd0;
                o_state.phase       = (i_rx_byte == 8'd0) ? fpr_pkg::PH_CHECK
                                                          : fpr_pkg::PH_DATA;
            end
            fpr_pkg::PH_DATA: begin
                o_result.valid         = 1'b1;
                o_result.kind          = fpr_pkg::KIND_DATA;
                o_result.payload_byte  = i_rx_byte;
                o_result.payload_index = i_state.byte_count;
                o_state.running_xor    = i_state.running_xor ^ i_rx_byte;
                o_state.byte_count     = count_inc;
                if (count_inc >= i_state.length_seen) begin
                    o_state.phase = fpr_pkg::PH_CHECK;
                end
            end
            fpr_pkg::PH_CHECK: begin
                o_state.checksum_seen = i_rx_byte;
                o_state.phase         = fpr_pkg::PH_END;
            end
            fpr_pkg::PH_END: begin
                o_result.valid = 1'b1;
                priority if (i_rx_byte != fpr_pkg::END_BYTE) begin
                    o_result.kind = fpr_pkg::KIND_NOEND;
                end else if (i_state.checksum_seen == i_state.running_xor) begin
                    o_result.kind = fpr_pkg::KIND_GOOD;
                end else begin
                    o_result.kind = fpr_pkg::KIND_BADSUM;
                end
                o_state.phase = fpr_pkg::PH_HUNT;
            end
            default: begin
                o_state.phase = fpr_pkg::PH_HUNT;
            end
        endcase
    end

endmodule

### rtl/framed_packet_receiver.sv
// Deframes STX/length/payload/XOR/ETX packets from a byte stream. One byte is
// taken per cycle while o_stall is low; the frame state updates in the same
// cycle and any result (a payload byte with its index, or the frame verdict)
// lands in a single output register, valid in the cycle after the transfer.
// o_stall is raised only while that register holds a result the downstream
// side is stalling, which is what limits the input rate below one per cycle.
module framed_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic [7:0] o_frame_length
);

    fpr_pkg::t_state  r_state;
    fpr_pkg::t_state  n_state;
    fpr_pkg::t_result step_res;
    logic             r_out_valid;
    logic             n_out_valid;
    fpr_pkg::t_result r_out;
    logic             accept;
    logic             out_free;

    fpr_step u_step (
        .i_state   (r_state),
        .i_rx_byte (i_rx_byte),
        .o_state   (n_state),
        .o_result  (step_res)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !out_free;
    assign accept   = i_valid && out_free;

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = accept && step_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: fpr_pkg::PH_HUNT, default: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && step_res.valid) begin
            r_out <= step_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_frame_length  = r_out.frame_length;

endmodule

### rtl/fpr_checker.sv
module fpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_payload_byte,
    input logic [7:0] o_payload_index,
    input logic [7:0] o_frame_length
);

    // held result under stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_payload_byte)
            && $stable(o_payload_index) && $stable(o_frame_length))
        else $error("result changed while stalled");

    // input back-pressure only from a stalled result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("o_stall without stalled result");

    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != fpr_pkg::KIND_DATA |->
            o_payload_byte == 8'd0 && o_payload_index == 8'd0)
        else $error("verdict carries payload");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == fpr_pkg::KIND_DATA |-> o_payload_index < o_frame_length)
        else $error("payload index beyond frame length");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_rx_byte       (i_rx_byte),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_payload_byte  (o_payload_byte),
    .o_payload_index (o_payload_index),
    .o_frame_length  (o_frame_length)
);

### verif/tb_framed_packet_receiver.sv
`timescale 1ns / 1ps

module tb_framed_packet_receiver;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DIR_ROWS       = 23;

    typedef struct packed {
        fpr_pkg::t_kind kind;
        logic [7:0]     payload_byte;
        logic [7:0]     payload_index;
        logic [7:0]     frame_length;
    } t_rx_result;

    typedef struct packed {
        logic [7:0] rx;
        bit         typed;
        t_rx_result want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_payload_byte;
    logic [7:0] o_payload_index;
    logic [7:0] o_frame_length;

    // predictor state
    fpr_pkg::t_phase ph = fpr_pkg::PH_HUNT;
    logic [7:0]      len_seen = 8'h00;
    logic [7:0]      cnt = 8'h00;
    logic [7:0]      xsum = 8'h00;
    logic [7:0]      csum_seen = 8'h00;

    t_rx_result pending_results[$];
    t_rx_result front_result;
    t_dir_row   dir_rows[DIR_ROWS];

    int errors = 0;
    int framed_bytes = 0;
    int bytes_sent = 0;
    int kind_counts[4] = '{0, 0, 0, 0};
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stuck_cycles = 0;

    framed_packet_receiver i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_length  (o_frame_length)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic bit deframe_byte(input logic [7:0] b, output t_rx_result r);
        bit has;
        has = 1'b0;
        r = '0;
        if (ph != fpr_pkg::PH_HUNT || b == fpr_pkg::START_BYTE) begin
            framed_bytes++;
        end
        case (ph)
            fpr_pkg::PH_HUNT: begin
                if (b == fpr_pkg::START_BYTE) begin
                    xsum = 8'h00;
                    ph = fpr_pkg::PH_LENGTH;
                end
            end
            fpr_pkg::PH_LENGTH: begin
                len_seen = b;
                xsum = xsum ^ b;
                cnt = 8'h00;
                ph = (b == 8'h00) ? fpr_pkg::PH_CHECK : fpr_pkg::PH_DATA;
            end
            fpr_pkg::PH_DATA: begin
                r = '{fpr_pkg::KIND_DATA, b, cnt, len_seen};
                has = 1'b1;
                xsum = xsum ^ b;
                cnt = cnt + 8'd1;
                if (cnt >= len_seen) begin
                    ph = fpr_pkg::PH_CHECK;
                end
            end
            fpr_pkg::PH_CHECK: begin
                csum_seen = b;
                ph = fpr_pkg::PH_END;
            end
            fpr_pkg::PH_END: begin
                if (b != fpr_pkg::END_BYTE) begin
                    r = '{fpr_pkg::KIND_NOEND, 8'h00, 8'h00, len_seen};
                end else if (csum_seen == xsum) begin
                    r = '{fpr_pkg::KIND_GOOD, 8'h00, 8'h00, len_seen};
                end else begin
                    r = '{fpr_pkg::KIND_BADSUM, 8'h00, 8'h00, len_seen};
                end
                has = 1'b1;
                ph = fpr_pkg::PH_HUNT;
            end
            default: begin
                ph = fpr_pkg::PH_HUNT;
            end
        endcase
        return has;
    endfunction

    // returns at the rising edge at which the byte is transferred
    task automatic drive_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_rx_result r;
        drive_byte(b);
        if (deframe_byte(b, r)) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic send_frame(input int len, input bit sum_ok, input bit end_ok, input int cut);
        logic [7:0] x;
        logic [7:0] b;
        int total;
        x = len[7:0];
        total = len + 4;
        for (int i = 0; i < total; i++) begin
            if (cut >= 0 && i >= cut) begin
                break;
            end
            if (i == 0) begin
                b = fpr_pkg::START_BYTE;
            end else if (i == 1) begin
                b = len[7:0];
            end else if (i < len + 2) begin
                if ($urandom_range(0, 7) == 0) begin
                    b = fpr_pkg::START_BYTE + 8'($urandom_range(0, 1));
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                x = x ^ b;
            end else if (i == len + 2) begin
                b = sum_ok ? x : x ^ 8'($urandom_range(1, 255));
            end else begin
                b = end_ok ? fpr_pkg::END_BYTE : fpr_pkg::END_BYTE ^ 8'($urandom_range(1, 255));
            end
            push_byte(b);
        end
    endtask

    task automatic run_traffic(input int quota);
        int start;
        int r;
        int len;
        start = framed_bytes;
        while (framed_bytes - start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                send_frame(len, $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 85, -1);
            end else if (r < 82) begin
                len = $urandom_range(1, 12);
                send_frame(len, 1'b1, 1'b1, $urandom_range(1, len + 3));
            end else if (r < 95) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                send_frame($urandom_range(13, 40), 1'b1, 1'b1, -1);
            end
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, kind", o_kind, 0);
            end else begin
                front_result = pending_results.pop_front();
                if (o_kind !== front_result.kind) begin
                    report_mismatch("kind", o_kind, front_result.kind);
                end
                if (o_payload_byte !== front_result.payload_byte) begin
                    report_mismatch("payload_byte", o_payload_byte, front_result.payload_byte);
                end
                if (o_payload_index !== front_result.payload_index) begin
                    report_mismatch("payload_index", o_payload_index,
                                    front_result.payload_index);
                end
                if (o_frame_length !== front_result.frame_length) begin
                    report_mismatch("frame_length", o_frame_length, front_result.frame_length);
                end
            end
            kind_counts[o_kind]++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        t_rx_result r;
        bit has;

        dir_rows = '{
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{fpr_pkg::START_BYTE, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{fpr_pkg::END_BYTE, 1'b1, '{fpr_pkg::KIND_GOOD, 8'h00, 8'h00, 8'h00}},
            '{fpr_pkg::START_BYTE, 1'b0, '0},
            '{8'h02, 1'b0, '0},
            '{8'h00, 1'b1, '{fpr_pkg::KIND_DATA, 8'h00, 8'h00, 8'h02}},
            '{8'hFF, 1'b1, '{fpr_pkg::KIND_DATA, 8'hFF, 8'h01, 8'h02}},
            '{8'h11, 1'b0, '0},
            '{fpr_pkg::END_BYTE, 1'b1, '{fpr_pkg::KIND_BADSUM, 8'h00, 8'h00, 8'h02}},
            '{fpr_pkg::START_BYTE, 1'b0, '0},
            '{8'h01, 1'b0, '0},
            '{fpr_pkg::START_BYTE, 1'b1,
              '{fpr_pkg::KIND_DATA, fpr_pkg::START_BYTE, 8'h00, 8'h01}},
            '{8'h03, 1'b0, '0},
            '{fpr_pkg::START_BYTE, 1'b1, '{fpr_pkg::KIND_NOEND, 8'h00, 8'h00, 8'h01}},
            '{8'h01, 1'b0, '0},
            '{fpr_pkg::START_BYTE, 1'b0, '0},
            '{8'h01, 1'b0, '0},
            '{8'h80, 1'b1, '{fpr_pkg::KIND_DATA, 8'h80, 8'h00, 8'h01}},
            '{8'h81, 1'b0, '0},
            '{fpr_pkg::END_BYTE, 1'b1, '{fpr_pkg::KIND_GOOD, 8'h00, 8'h00, 8'h01}}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            drive_byte(dir_rows[i].rx);
            has = deframe_byte(dir_rows[i].rx, r);
            if (dir_rows[i].typed) begin
                if (!has || r != dir_rows[i].want) begin
                    report_mismatch($sformatf("directed row %0d prediction", i), int'(r),
                                    int'(dir_rows[i].want));
                end
                pending_results.push_back(dir_rows[i].want);
            end else if (has) begin
                pending_results.push_back(r);
            end
        end

        // no idling: longest frame, then a long receiver hold-off
        send_frame(255, 1'b1, 1'b1, -1);
        hold_req++;
        send_frame(20, 1'b1, 1'b1, -1);
        wait_drained();
        run_traffic(180);

        sender_idle_pct = 74;
        run_traffic(200);

        sender_idle_pct = 0;
        recv_stall_pct = 74;
        run_traffic(200);

        sender_idle_pct = 27;
        recv_stall_pct = 27;
        run_traffic(200);

        wait_drained();
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", pending_results.size(), 0);
        end

        $display("Sent %0d bytes, %0d inside frames; checked %0d payload bytes",
                 bytes_sent, framed_bytes, kind_counts[fpr_pkg::KIND_DATA]);
        $display("Verdicts: %0d good, %0d checksum mismatch, %0d end byte missing",
                 kind_counts[fpr_pkg::KIND_GOOD], kind_counts[fpr_pkg::KIND_BADSUM],
                 kind_counts[fpr_pkg::KIND_NOEND]);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
